@@ rtl/core/lav_pkg.sv @@
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants, tables and helpers for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int RSQRT_ITERS_DEF = 4;

    // Q30 fixed-point constants of the reciprocal square root unit
    localparam logic [31:0] THREE_Q30 = 32'd3221225472;
    localparam logic [31:0] YMAX      = 32'd2415919104;
    localparam int          SEED_LAST = 23;

    // register index, taken from paddr[2]
    localparam logic REG_HANDEDNESS = 1'b0;

    localparam logic HAND_LEFT = 1'b0;

    localparam logic [1:0] LAST_COL = 2'd3;

    // 1/sqrt seed table, Q8, indexed by t[31:27]
    localparam logic [10:0] SEED_Q8 [24] = '{
        11'd1024, 11'd591, 11'd458, 11'd387, 11'd341, 11'd309, 11'd284, 11'd264,
        11'd248,  11'd235, 11'd223, 11'd214, 11'd205, 11'd197, 11'd190, 11'd184,
        11'd178,  11'd173, 11'd168, 11'd164, 11'd160, 11'd156, 11'd153, 11'd149
    };

    // bit length of one byte
    function automatic logic [3:0] len8(input logic [7:0] b);
        logic [3:0] l;
        l = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                l = 4'(i + 1);
            end
        end
        return l;
    endfunction

endpackage

@@ rtl/core/look_at_view_matrix.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Fixed-point look-at view matrix: forward, right and true up bases with
// their eye translations, sent as four column transactions.
// ----------------------------------------------------------------------------
// Path: input register, forward normalizer, cross product, right normalizer,
//   true up, eye translations, column register; each normalizer is 9 + 3*RSQRT_ITERS stages.
// Flow: the pipeline advances only when the single result port, which carries
//   four columns per item, takes a new item; the pipeline holds many items.
// Reset: valid bits, column counter and handedness (left-handed) clear.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
    parameter int FRAC_BITS   = lav_pkg::FRAC_BITS_DEF,
    parameter int RSQRT_ITERS = lav_pkg::RSQRT_ITERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] tgt_x,
    input  logic signed [31:0] tgt_y,
    input  logic signed [31:0] tgt_z,
    input  logic signed [31:0] up_x,
    input  logic signed [31:0] up_y,
    input  logic signed [31:0] up_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         col_index,
    output logic signed [31:0] elem_0,
    output logic signed [31:0] elem_1,
    output logic signed [31:0] elem_2,
    output logic signed [31:0] elem_3,
    output logic               degenerate,
    output logic               saturated,
    output logic               last
);
    import lav_pkg::*;

    localparam int FB  = FRAC_BITS;
    localparam int UW  = FB + 4;
    localparam int BW  = UW + 1;
    localparam int CW  = 32 + UW;
    localparam int PW1 = 192;
    localparam int PW2 = 3 * UW + 97;
    localparam int FW  = 2 * UW + 1;
    localparam int DW  = BW + 34;
    localparam int RW  = DW + 2 - FB;

    logic en;
    logic hand_reg;

    // ---------------- configuration -----------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HANDEDNESS) ? {31'b0, hand_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hand_reg <= HAND_LEFT;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_HANDEDNESS)
        begin
            hand_reg <= pwdata[0];
        end
    end

    assign in_stall = !en;

    // ---------------- input stage: view direction ---------------------------
    logic signed [31:0] pin [3];
    logic signed [31:0] tin [3];
    logic signed [31:0] uin [3];
    logic               t0_v_reg;
    logic signed [31:0] pos0_reg [3];
    logic signed [31:0] up0_reg [3];
    logic signed [32:0] d0_reg [3];

    assign pin = '{pos_x, pos_y, pos_z};
    assign tin = '{tgt_x, tgt_y, tgt_z};
    assign uin = '{up_x, up_y, up_z};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos0_reg[i] <= pin[i];
                up0_reg[i]  <= uin[i];
                d0_reg[i]   <= (hand_reg == HAND_LEFT) ? 33'(tin[i]) - 33'(pin[i])
                                                       : 33'(pin[i]) - 33'(tin[i]);
            end
        end
    end

    // ---------------- forward normalize -------------------------------------
    logic              n1_v;
    logic signed [UW-1:0] f_n [3];
    logic              z1;
    logic [PW1-1:0]    pay1;

    lav_norm #(.IW(33), .FB(FB), .ITERS(RSQRT_ITERS), .PW(PW1)) u_norm_f (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t0_v_reg),
        .in_v(d0_reg),
        .in_pay({pos0_reg[0], pos0_reg[1], pos0_reg[2], up0_reg[0], up0_reg[1], up0_reg[2]}),
        .out_valid(n1_v), .out_u(f_n), .out_zero(z1), .out_pay(pay1)
    );

    logic signed [31:0] pos1 [3];
    logic signed [31:0] up1 [3];

    assign pos1 = '{pay1[191:160], pay1[159:128], pay1[127:96]};
    assign up1  = '{pay1[95:64], pay1[63:32], pay1[31:0]};

    // ---------------- cross(up, f) ------------------------------------------
    logic                 c1_v_reg, c2_v_reg;
    logic signed [CW-1:0] cp_reg [6];
    logic signed [UW-1:0] f1_reg [3], f2_reg [3];
    logic signed [31:0]   pos1_reg [3], pos2_reg [3];
    logic                 z1_1_reg, z1_2_reg;
    logic signed [CW-1:0] c2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp_reg[0] <= CW'(up1[1]) * CW'(f_n[2]);
            cp_reg[1] <= CW'(up1[2]) * CW'(f_n[1]);
            cp_reg[2] <= CW'(up1[2]) * CW'(f_n[0]);
            cp_reg[3] <= CW'(up1[0]) * CW'(f_n[2]);
            cp_reg[4] <= CW'(up1[0]) * CW'(f_n[1]);
            cp_reg[5] <= CW'(up1[1]) * CW'(f_n[0]);
            f1_reg    <= f_n;
            pos1_reg  <= pos1;
            z1_1_reg  <= z1;
            c2_reg[0] <= cp_reg[0] - cp_reg[1];
            c2_reg[1] <= cp_reg[2] - cp_reg[3];
            c2_reg[2] <= cp_reg[4] - cp_reg[5];
            f2_reg    <= f1_reg;
            pos2_reg  <= pos1_reg;
            z1_2_reg  <= z1_1_reg;
        end
    end

    // ---------------- right normalize ---------------------------------------
    logic                 n2_v;
    logic signed [UW-1:0] r_n [3];
    logic                 z2;
    logic [PW2-1:0]       pay2;

    lav_norm #(.IW(CW), .FB(FB), .ITERS(RSQRT_ITERS), .PW(PW2)) u_norm_r (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(c2_v_reg),
        .in_v(c2_reg),
        .in_pay({f2_reg[0], f2_reg[1], f2_reg[2],
                 pos2_reg[0], pos2_reg[1], pos2_reg[2], z1_2_reg}),
        .out_valid(n2_v), .out_u(r_n), .out_zero(z2), .out_pay(pay2)
    );

    logic signed [UW-1:0] f3 [3];
    logic signed [31:0]   pos3 [3];
    logic                 deg3;

    assign f3   = '{pay2[3*UW+96 -: UW], pay2[2*UW+96 -: UW], pay2[UW+96 -: UW]};
    assign pos3 = '{pay2[96:65], pay2[64:33], pay2[32:1]};
    assign deg3 = pay2[0] | z2;

    // ---------------- true up = cross(f, r), rounded -------------------------
    logic                 u1_v_reg, u2_v_reg;
    logic signed [2*UW-1:0] fr_reg [6];
    logic signed [UW-1:0] fu1_reg [3], ru1_reg [3], fu2_reg [3], ru2_reg [3];
    logic signed [31:0]   posu1_reg [3], posu2_reg [3];
    logic                 degu1_reg, degu2_reg;
    logic signed [FW-1:0] dff [3];
    logic [FW-1:0]        dmag [3];
    logic [FW:0]          drnd [3];
    logic signed [BW-1:0] u_c [3];
    logic signed [BW-1:0] u2_reg [3];

    always_comb
    begin
        dff[0] = FW'(fr_reg[0]) - FW'(fr_reg[1]);
        dff[1] = FW'(fr_reg[2]) - FW'(fr_reg[3]);
        dff[2] = FW'(fr_reg[4]) - FW'(fr_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            dmag[i] = dff[i][FW-1] ? FW'(-dff[i]) : FW'(dff[i]);
            drnd[i] = ((FW+1)'(dmag[i]) + ((FW+1)'(1) << (FB - 1))) >> FB;
            u_c[i]  = dff[i][FW-1] ? -$signed(BW'(drnd[i])) : $signed(BW'(drnd[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fr_reg[0] <= (2*UW)'(f3[1]) * (2*UW)'(r_n[2]);
            fr_reg[1] <= (2*UW)'(f3[2]) * (2*UW)'(r_n[1]);
            fr_reg[2] <= (2*UW)'(f3[2]) * (2*UW)'(r_n[0]);
            fr_reg[3] <= (2*UW)'(f3[0]) * (2*UW)'(r_n[2]);
            fr_reg[4] <= (2*UW)'(f3[0]) * (2*UW)'(r_n[1]);
            fr_reg[5] <= (2*UW)'(f3[1]) * (2*UW)'(r_n[0]);
            fu1_reg   <= f3;
            ru1_reg   <= r_n;
            posu1_reg <= pos3;
            degu1_reg <= deg3;
            u2_reg    <= u_c;
            fu2_reg   <= fu1_reg;
            ru2_reg   <= ru1_reg;
            posu2_reg <= posu1_reg;
            degu2_reg <= degu1_reg;
        end
    end

    // ---------------- eye translations --------------------------------------
    logic                  d1_v_reg, d2_v_reg, d3_v_reg;
    logic signed [BW-1:0]  bas_c [3][3];
    logic signed [BW+31:0] dp_reg [3][3];
    logic signed [BW-1:0]  b1_reg [3][3], b2_reg [3][3], b3_reg [3][3];
    logic                  dg1_reg, dg2_reg, dg3_reg;
    logic signed [DW-1:0]  dot_reg [3];
    logic [DW-1:0]         dotm [3];
    logic [DW:0]           dotr [3];
    logic signed [RW-1:0]  nv [3];
    logic [31:0]           e3_c [3];
    logic [2:0]            sat_c;
    logic [31:0]           e3_reg [3];
    logic [2:0]            sat_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bas_c[0][i] = BW'(ru2_reg[i]);
            bas_c[1][i] = u2_reg[i];
            bas_c[2][i] = BW'(fu2_reg[i]);
        end
        for (int k = 0; k < 3; k++)
        begin
            dotm[k] = dot_reg[k][DW-1] ? DW'(-dot_reg[k]) : DW'(dot_reg[k]);
            dotr[k] = ((DW+1)'(dotm[k]) + ((DW+1)'(1) << (FB - 1))) >> FB;
            // -round(dot) equals round(-dot)
            nv[k]   = dot_reg[k][DW-1] ? $signed(RW'(dotr[k])) : -$signed(RW'(dotr[k]));
            sat_c[k] = 1'b0;
            e3_c[k]  = 32'(nv[k]);
            if (nv[k] > RW'(32'sh7fffffff))
            begin
                e3_c[k]  = 32'h7fffffff;
                sat_c[k] = 1'b1;
            end
            else if (nv[k] < -RW'(33'sh080000000))
            begin
                e3_c[k]  = 32'h80000000;
                sat_c[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dp_reg[k][i] <= (BW+32)'(bas_c[k][i]) * (BW+32)'(posu2_reg[i]);
                end
                dot_reg[k] <= DW'(dp_reg[k][0]) + DW'(dp_reg[k][1]) + DW'(dp_reg[k][2]);
            end
            b1_reg  <= bas_c;
            dg1_reg <= degu2_reg;
            b2_reg  <= b1_reg;
            dg2_reg <= dg1_reg;
            e3_reg  <= e3_c;
            sat_reg <= sat_c;
            b3_reg  <= b2_reg;
            dg3_reg <= dg2_reg;
        end
    end

    // ---------------- valid bits of the top-level stages ---------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_v_reg <= 1'b0;
            c1_v_reg <= 1'b0;
            c2_v_reg <= 1'b0;
            u1_v_reg <= 1'b0;
            u2_v_reg <= 1'b0;
            d1_v_reg <= 1'b0;
            d2_v_reg <= 1'b0;
            d3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t0_v_reg <= in_valid;
            c1_v_reg <= n1_v;
            c2_v_reg <= c1_v_reg;
            u1_v_reg <= n2_v;
            u2_v_reg <= u1_v_reg;
            d1_v_reg <= u2_v_reg;
            d2_v_reg <= d1_v_reg;
            d3_v_reg <= d2_v_reg;
        end
    end

    // ---------------- column output ------------------------------------------
    lav_colser #(.FB(FB), .BW(BW)) u_colser (
        .clk(clk), .rst_n(rst_n),
        .in_valid(d3_v_reg), .in_b(b3_reg), .in_e3(e3_reg), .in_sat(sat_reg),
        .in_degen(dg3_reg), .load(en),
        .out_valid(out_valid), .out_stall(out_stall), .col_index(col_index),
        .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
        .degenerate(degenerate), .saturated(saturated), .last(last)
    );

endmodule

@@ rtl/core/lav_norm.sv @@
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: block scaling, sum of squares, seeded
// Newton reciprocal square root, and a rounded scale of each component.
// ----------------------------------------------------------------------------
module lav_norm #(
    parameter int IW    = 33,
    parameter int FB    = 16,
    parameter int ITERS = 4,
    parameter int PW    = 1,
    localparam int UW   = FB + 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [IW-1:0] in_v [3],
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    output logic signed [UW-1:0] out_u [3],
    output logic                 out_zero,
    output logic [PW-1:0]        out_pay
);
    import lav_pkg::*;

    localparam int NG = (IW + 7) / 8;
    localparam int GW = NG * 8;
    localparam int LW = $clog2(IW + 1);
    localparam int SH = 60 - FB;
    localparam int L  = 9 + 3 * ITERS;
    localparam int SW = PW + 4;

    // ---------------- sideband line: zero flag, signs, payload -------------
    logic [L-1:0]  vld_reg;
    logic [SW-1:0] side_reg [L];
    logic          zero_in;
    logic [2:0]    neg_in;

    assign zero_in = (in_v[0] == '0) && (in_v[1] == '0) && (in_v[2] == '0);
    assign neg_in  = {in_v[2][IW-1], in_v[1][IW-1], in_v[0][IW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[L-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= {zero_in, neg_in, in_pay};
            for (int j = 1; j < L; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // ---------------- magnitudes and maximum --------------------------------
    logic [IW-1:0] m_in [3];
    logic [IW-1:0] mx_in;
    logic [IW-1:0] m0_reg [3];
    logic [IW-1:0] mx0_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_in[i] = in_v[i][IW-1] ? IW'(-in_v[i]) : IW'(in_v[i]);
        end
        mx_in = (m_in[0] > m_in[1]) ? m_in[0] : m_in[1];
        if (m_in[2] > mx_in)
        begin
            mx_in = m_in[2];
        end
    end

    // ---------------- bit length, per byte then combined --------------------
    logic [GW-1:0] mxg;
    logic [3:0]    gl_c  [NG];
    logic [3:0]    gl1_reg [NG];
    logic [IW-1:0] m1_reg [3];
    logic [LW-1:0] len_c;
    logic [LW-1:0] len2_reg;
    logic [IW-1:0] m2_reg [3];

    assign mxg = GW'(mx0_reg);

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            gl_c[g] = len8(mxg[g*8 +: 8]);
        end
        len_c = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (gl1_reg[g] != 4'd0)
            begin
                len_c = LW'(g * 8) + LW'(gl1_reg[g]);
            end
        end
    end

    // ---------------- scale largest to [2^29, 2^30), squares, sum, seed -----
    logic [IW+29:0] wide [3];
    logic [29:0]    ms3_reg [3];
    logic [59:0]    sq_c [3];
    logic [59:0]    sq4_reg [3];
    logic [29:0]    ms4_reg [3];
    logic [61:0]    sum_c;
    logic [31:0]    t5_reg;
    logic [29:0]    ms5_reg [3];
    logic [4:0]     sidx;
    logic [32:0]    seed_y;
    logic [31:0]    y_seed;

    // iteration pipeline
    logic [31:0] yi_reg [ITERS+1];
    logic [31:0] ti_reg [ITERS+1];
    logic [29:0] mi_reg [ITERS+1][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wide[i] = {m2_reg[i], 30'b0} >> len2_reg;
            sq_c[i] = 60'(ms3_reg[i]) * 60'(ms3_reg[i]);
        end
        sum_c  = 62'(sq4_reg[0]) + 62'(sq4_reg[1]) + 62'(sq4_reg[2]);
        sidx   = (t5_reg[31:27] > 5'(SEED_LAST)) ? 5'(SEED_LAST) : t5_reg[31:27];
        seed_y = {SEED_Q8[sidx], 22'b0};
        y_seed = (seed_y > 33'(YMAX)) ? YMAX : seed_y[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg  <= m_in;
            mx0_reg <= mx_in;
            gl1_reg <= gl_c;
            m1_reg  <= m0_reg;
            len2_reg <= len_c;
            m2_reg  <= m1_reg;
            for (int i = 0; i < 3; i++)
            begin
                ms3_reg[i] <= wide[i][29:0];
            end
            sq4_reg <= sq_c;
            ms4_reg <= ms3_reg;
            t5_reg  <= sum_c[61:30];
            ms5_reg <= ms4_reg;
            yi_reg[0] <= y_seed;
            ti_reg[0] <= t5_reg;
            mi_reg[0] <= ms5_reg;
        end
    end

    // ---------------- Newton steps, three stages each -----------------------
    logic [33:0] a_y2 [ITERS];
    logic [31:0] a_y  [ITERS];
    logic [31:0] a_t  [ITERS];
    logic [29:0] a_m  [ITERS][3];
    logic [31:0] b_corr [ITERS];
    logic [31:0] b_y  [ITERS];
    logic [31:0] b_t  [ITERS];
    logic [29:0] b_m  [ITERS][3];

    for (genvar k = 0; k < ITERS; k++)
    begin : g_iter
        logic [63:0] yy;
        logic [65:0] ty;
        logic [33:0] ty2;
        logic [31:0] corr;
        logic [63:0] yc;
        logic [32:0] ynew;

        assign yy   = 64'(yi_reg[k]) * 64'(yi_reg[k]);
        assign ty   = 66'(a_t[k]) * 66'(a_y2[k]);
        assign ty2  = ty[63:30];
        assign corr = (ty2 >= 34'(THREE_Q30)) ? '0 : 32'(34'(THREE_Q30) - ty2);
        assign yc   = 64'(b_y[k]) * 64'(b_corr[k]);
        assign ynew = yc[63:31];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_y2[k]   <= yy[63:30];
                a_y[k]    <= yi_reg[k];
                a_t[k]    <= ti_reg[k];
                a_m[k]    <= mi_reg[k];
                b_corr[k] <= corr;
                b_y[k]    <= a_y[k];
                b_t[k]    <= a_t[k];
                b_m[k]    <= a_m[k];
                yi_reg[k+1] <= (ynew > 33'(YMAX)) ? YMAX : ynew[31:0];
                ti_reg[k+1] <= b_t[k];
                mi_reg[k+1] <= b_m[k];
            end
        end
    end

    // ---------------- scale components, round half up on magnitude ----------
    logic [61:0]   pf_reg [3];
    logic [61:0]   rnd [3];
    logic [UW-2:0] um_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = (pf_reg[i] + (62'(1) << (SH - 1))) >> SH;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pf_reg[i] <= 62'(mi_reg[ITERS][i]) * 62'(yi_reg[ITERS]);
                um_reg[i] <= rnd[i][UW-2:0];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_u[i] = side_reg[L-1][PW+i] ? -$signed({1'b0, um_reg[i]})
                                           :  $signed({1'b0, um_reg[i]});
        end
    end

    assign out_valid = vld_reg[L-1];
    assign out_zero  = side_reg[L-1][PW+3];
    assign out_pay   = side_reg[L-1][PW-1:0];

endmodule

@@ rtl/core/lav_colser.sv @@
// ----------------------------------------------------------------------------
// lav_colser
// Column serializer: holds one finished matrix and sends its four columns,
// one transaction per column, and gates the pipeline advance.
// ----------------------------------------------------------------------------
module lav_colser #(
    parameter int FB = 16,
    parameter int BW = FB + 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [BW-1:0] in_b [3][3],
    input  logic [31:0]          in_e3 [3],
    input  logic [2:0]           in_sat,
    input  logic                 in_degen,
    output logic                 load,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           col_index,
    output logic signed [31:0]   elem_0,
    output logic signed [31:0]   elem_1,
    output logic signed [31:0]   elem_2,
    output logic signed [31:0]   elem_3,
    output logic                 degenerate,
    output logic                 saturated,
    output logic                 last
);
    import lav_pkg::*;

    logic                 ov_reg, ov_next;
    logic [1:0]           col_reg, col_next;
    logic signed [BW-1:0] b_reg [3][3];
    logic [31:0]          e3_reg [3];
    logic [2:0]           sat_reg;
    logic                 deg_reg;

    assign load = !ov_reg || (!out_stall && col_reg == LAST_COL);

    always_comb
    begin
        ov_next  = ov_reg;
        col_next = col_reg;
        if (load)
        begin
            ov_next  = in_valid;
            col_next = '0;
        end
        else if (ov_reg && !out_stall)
        begin
            col_next = col_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            col_reg <= '0;
        end
        else
        begin
            ov_reg  <= ov_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_reg   <= in_b;
            e3_reg  <= in_e3;
            sat_reg <= in_sat;
            deg_reg <= in_degen;
        end
    end

    always_comb
    begin
        elem_0    = '0;
        elem_1    = '0;
        elem_2    = '0;
        elem_3    = 32'sd1 <<< FB;
        saturated = 1'b0;
        if (col_reg != LAST_COL)
        begin
            elem_0    = 32'(b_reg[col_reg][0]);
            elem_1    = 32'(b_reg[col_reg][1]);
            elem_2    = 32'(b_reg[col_reg][2]);
            elem_3    = $signed(e3_reg[col_reg]);
            saturated = sat_reg[col_reg];
        end
    end

    assign out_valid  = ov_reg;
    assign col_index  = col_reg;
    assign degenerate = deg_reg;
    assign last       = (col_reg == LAST_COL);

endmodule
